>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks for the RTL files that assert.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Beat types, command and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int CMD_W     = 3;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 3;
  localparam int POS_W     = 6;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [ST_W-1:0] ST_MATCH   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOMATCH = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
    logic                    last;
  } out_beat_t;

  typedef enum logic [1:0] {
    EK_CODE,
    EK_POP,
    EK_FINAL
  } emit_kind_t;

  typedef struct packed {
    logic            latch_in;
    logic            do_push;
    logic            do_pop;
    logic            walk_start;
    logic            walk_step;
    logic            emit;
    emit_kind_t      emit_kind;
    logic [ST_W-1:0] emit_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             out_free;
    logic             hit;
    logic             hold_valid;
    logic             walk_end;
  } dp_stat_t;

endpackage

>>> hdl/bounded_deque_with_search_top.sv
// ----------------------------------------------------------------------------
// Bounded deque with search, top level
// Push: result registered from the decode state; pop: from the pop-read state.
// Search/dump: one entry per cycle from a ring memory read, except while a hit
// must pass the held match on and the output register is not free.
// One item at a time; next beat accepted after the last result is loaded.
// Synchronous active-low reset empties the deque; entry memory is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_deque_with_search_top import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_emit_free, clk, rst_n, ctrl.emit || ctrl.walk_step && stat.hit && stat.hold_valid, stat.out_free)
  `ASSERT_IMPL(a_push_room, clk, rst_n, ctrl.do_push, !stat.full)
  `ASSERT_IMPL(a_pop_data, clk, rst_n, ctrl.do_pop || ctrl.walk_start, !stat.empty)

endmodule

>>> hdl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded deque controller
// Sequences decode, pop read, entry walk and final result of one command.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctrl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_POPRD  = 5'b00100,
    S_WALK   = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctrl      = '0;
    ctrl.emit_kind = EK_CODE;
    ctrl.emit_code = ST_OK;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.latch_in = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (stat.out_free) begin
              ctrl.emit      = 1'b1;
              ctrl.emit_code = stat.full ? ST_FULL : ST_OK;
              ctrl.do_push   = !stat.full;
              state_nxt      = S_IDLE;
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                ctrl.emit      = 1'b1;
                ctrl.emit_code = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              ctrl.do_pop = 1'b1;
              state_nxt   = S_POPRD;
            end
          end
          CMD_SEARCH, CMD_DUMP: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                ctrl.emit      = 1'b1;
                ctrl.emit_code = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              ctrl.walk_start = 1'b1;
              state_nxt       = S_WALK;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_POPRD: begin
        if (stat.out_free) begin
          ctrl.emit      = 1'b1;
          ctrl.emit_kind = EK_POP;
          state_nxt      = S_IDLE;
        end
      end
      S_WALK: begin
        // a hit with an entry already held pushes that entry out, so it needs the output register
        if (!(stat.hit && stat.hold_valid && !stat.out_free)) begin
          ctrl.walk_step = 1'b1;
          if (stat.walk_end) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctrl.emit      = 1'b1;
          ctrl.emit_kind = EK_FINAL;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/bdq_dp.sv
// ----------------------------------------------------------------------------
// Bounded deque datapath
// Entry ring memory, front/count pointers, walk index, held match, result reg.
// ----------------------------------------------------------------------------
module bdq_dp import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_data,
  input  ctrl_cmd_t ctrl,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW+1)'(DEPTH);

  logic [VAL_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0] cmd_r;
  logic [VAL_W-1:0] key_r;
  logic [AW-1:0]    front_r, front_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [VAL_W-1:0] rd_data_r;
  logic             hold_valid_r, hold_valid_nxt;
  logic [VAL_W-1:0] hold_val_r;
  logic [POS_W-1:0] hold_pos_r;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r;

  logic [AW-1:0]    off;
  logic [AW:0]      sum;
  logic [AW-1:0]    slot;
  logic [AW:0]      idx_p1;
  logic [POS_W-1:0] cur_pos;
  logic             full, empty, hit, walk_end, out_free;
  logic             wr_en, rd_en, out_load;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [ST_W-1:0]  hold_status;
  out_beat_t        out_beat;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign out_free = !out_valid_r || out_ready;
  assign hit      = (cmd_r == CMD_DUMP) || (rd_data_r == key_r);
  assign walk_end = ((CW'(idx_r) + CW'(1)) == count_r);
  assign idx_p1   = {1'b0, idx_r} + (AW+1)'(1);
  assign cur_pos  = POS_W'(idx_p1);
  assign hold_status = (cmd_r == CMD_DUMP) ? ST_OK : ST_MATCH;

  // ring slot of front + offset, one wrap at most
  always_comb begin
    if (ctrl.do_push)     off = AW'(count_r);
    else if (ctrl.do_pop) off = AW'(count_r - CW'(1));
    else                  off = idx_p1[AW-1:0];
  end
  assign sum  = {1'b0, front_r} + {1'b0, off};
  assign slot = (sum >= DEPTH_X) ? AW'(sum - DEPTH_X) : sum[AW-1:0];

  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    hold_valid_nxt = hold_valid_r;
    wr_en          = 1'b0;
    wr_addr        = slot;
    rd_en          = 1'b0;
    rd_addr        = slot;
    if (ctrl.do_push) begin
      wr_en     = 1'b1;
      count_nxt = count_r + CW'(1);
      if (cmd_r == CMD_PUSH_FRONT) begin
        front_nxt = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
        wr_addr   = front_nxt;
      end
    end
    if (ctrl.do_pop) begin
      rd_en     = 1'b1;
      count_nxt = count_r - CW'(1);
      if (cmd_r == CMD_POP_FRONT) begin
        rd_addr   = front_r;
        front_nxt = (front_r == LAST_SLOT) ? '0 : front_r + AW'(1);
      end
    end
    if (ctrl.walk_start) begin
      rd_en          = 1'b1;
      rd_addr        = front_r;
      idx_nxt        = '0;
      hold_valid_nxt = 1'b0;
    end
    if (ctrl.walk_step) begin
      idx_nxt = idx_p1[AW-1:0];
      rd_en   = !walk_end;
      if (hit) hold_valid_nxt = 1'b1;
    end
    if (ctrl.emit && ctrl.emit_kind == EK_FINAL) hold_valid_nxt = 1'b0;
  end

  always_comb begin
    out_load = 1'b0;
    out_beat = '0;
    if (ctrl.emit) begin
      out_load      = 1'b1;
      out_beat.last = 1'b1;
      case (ctrl.emit_kind)
        EK_CODE: out_beat.status = ctrl.emit_code;
        EK_POP: begin
          out_beat.status     = ST_OK;
          out_beat.item_value = rd_data_r;
        end
        EK_FINAL: begin
          if (hold_valid_r) begin
            out_beat.status     = hold_status;
            out_beat.item_value = hold_val_r;
            out_beat.position   = hold_pos_r;
          end else begin
            out_beat.status = ST_NOMATCH;
          end
        end
        default: out_beat.status = ctrl.emit_code;
      endcase
    end else if (ctrl.walk_step && hit && hold_valid_r) begin
      // a newer hit exists, so the held one is not last
      out_load            = 1'b1;
      out_beat.status     = hold_status;
      out_beat.item_value = hold_val_r;
      out_beat.position   = hold_pos_r;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= key_r;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      cmd_r <= in_data.command;
      key_r <= in_data.value;
    end
    idx_r <= idx_nxt;
    if (ctrl.walk_step && hit) begin
      hold_val_r <= rd_data_r;
      hold_pos_r <= cur_pos;
    end
    if (out_load) out_data_r <= out_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r      <= '0;
      count_r      <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.full       = full;
  assign stat.empty      = empty;
  assign stat.out_free   = out_free;
  assign stat.hit        = hit;
  assign stat.hold_valid = hold_valid_r;
  assign stat.walk_end   = walk_end;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
